/* sv/mrpt_pkg.sv */
// Package: defaults, verdict codes and the witness prime table for the Miller-Rabin unit.
package mrpt_pkg;

   localparam int unsigned WIDTH_DEF      = 64;
   localparam int unsigned BASE_DEPTH_DEF = 64;
   localparam int unsigned CAND_W         = 64;
   localparam int unsigned ROUNDS_W       = 7;
   localparam int unsigned VERDICT_W      = 2;
   localparam int unsigned PRIME_W        = 10;
   localparam int unsigned PRIME_CNT      = 128;

   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd20;

   localparam logic [VERDICT_W-1:0] VERDICT_COMPOSITE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PROBABLE  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd2;

   localparam logic [PRIME_W-1:0] PRIMES [PRIME_CNT] = '{
      10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
      10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
      10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
      10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
      10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
      10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
      10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
      10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
      10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
      10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
      10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
      10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
      10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
      10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
      10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
      10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719
   };

   typedef enum logic [1:0] {
      MUL_R = 2'd0,
      MUL_B = 2'd1,
      MUL_X = 2'd2
   } mul_kind_type;

endpackage

/* sv/mrpt_if.sv */
// Valid/ready channel interfaces for candidate requests and verdict responses.
interface mrpt_req_if;
   import mrpt_pkg::*;
   logic              valid;
   logic              ready;
   logic [CAND_W-1:0] candidate;
   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_rsp_if;
   import mrpt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [VERDICT_W-1:0] verdict;
   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

/* sv/miller_rabin_prime_test_unit.sv */
// Miller-Rabin unit: one transaction in, one verdict out, all modular multiplies on a shared mod-add unit.
// Timing: one candidate at a time. First p-1 is split into s * 2^t; each round then
// reduces the base, then does one modular multiply per set bit and per bit of s plus
// up to t squarings; every modular multiply runs on the single shared add-and-reduce
// datapath. The unit is not ready from acceptance until the verdict is taken; the
// register num_rounds (reset 20) is written through csr_we/csr_wdata.
module miller_rabin_prime_test_unit #(
   parameter int unsigned WIDTH            = mrpt_pkg::WIDTH_DEF,
   parameter int unsigned BASE_TABLE_DEPTH = mrpt_pkg::BASE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   mrpt_req_if.sink                      req_chan,
   mrpt_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [mrpt_pkg::ROUNDS_W-1:0] csr_wdata
);
   import mrpt_pkg::*;

   localparam int unsigned EW = (WIDTH > PRIME_W) ? WIDTH : PRIME_W;
   localparam int unsigned TW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam int unsigned DW = 11;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SPLIT  = 8'b0000_0010,
      ST_ROUND  = 8'b0000_0100,
      ST_REDUCE = 8'b0000_1000,
      ST_POW    = 8'b0001_0000,
      ST_MUL    = 8'b0010_0000,
      ST_SQ     = 8'b0100_0000,
      ST_RESP   = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [ROUNDS_W-1:0]  num_rounds_ff, num_rounds_in;
   logic [ROUNDS_W-1:0]  rounds_ff, rounds_in;
   logic [ROUNDS_W-1:0]  idx_ff, idx_in;
   logic [WIDTH-1:0]     p_ff, p_in;
   logic [WIDTH-1:0]     s_ff, s_in;
   logic [WIDTH-1:0]     e_ff, e_in;
   logic [TW-1:0]        t_ff, t_in;
   logic [TW-1:0]        j_ff, j_in;
   logic [EW-1:0]        base_ff, base_in;
   logic [WIDTH-1:0]     r_ff, r_in;
   logic [WIDTH-1:0]     b_ff, b_in;
   logic [WIDTH-1:0]     ma_ff, ma_in;
   logic [WIDTH-1:0]     mb_ff, mb_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;
   logic [TW-1:0]        cnt_ff, cnt_in;
   logic                 phase_ff, phase_in;
   mul_kind_type         kind_ff, kind_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;

   logic [WIDTH-1:0] add_x, add_y, add_out;
   logic [WIDTH:0]   add_sum;
   logic [WIDTH:0]   add_red;
   logic [PRIME_W-1:0] prime_sel;
   logic [ROUNDS_W-1:0] rounds_cap;
   logic [EW-1:0]    p_ext;

   // shared modular adder: (x + y) mod p, operands below p
   assign add_sum = {1'b0, add_x} + {1'b0, add_y};
   assign add_red = add_sum - {1'b0, p_ff};
   assign add_out = (add_sum >= {1'b0, p_ff}) ? add_red[WIDTH-1:0] : add_sum[WIDTH-1:0];

   assign add_x = acc_ff;
   assign add_y = phase_ff ? ma_ff : acc_ff;

   assign prime_sel  = PRIMES[idx_ff];
   assign p_ext      = EW'(p_ff);
   assign rounds_cap = (DW'(num_rounds_ff) > DW'(BASE_TABLE_DEPTH))
                       ? ROUNDS_W'(BASE_TABLE_DEPTH) : num_rounds_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.verdict = verdict_ff;

   always_comb begin
      state_in      = state_ff;
      num_rounds_in = csr_we ? csr_wdata : num_rounds_ff;
      rounds_in     = rounds_ff;
      idx_in        = idx_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      t_in          = t_ff;
      j_in          = j_ff;
      base_in       = base_ff;
      r_in          = r_ff;
      b_in          = b_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      verdict_in    = verdict_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               p_in      = req_chan.candidate[WIDTH-1:0];
               s_in      = req_chan.candidate[WIDTH-1:0] - WIDTH'(1);
               t_in      = '0;
               idx_in    = '0;
               rounds_in = rounds_cap;
               if (req_chan.candidate[WIDTH-1:0] < WIDTH'(2)) begin
                  verdict_in = VERDICT_COMPOSITE;
                  state_in   = ST_RESP;
               end else begin
                  state_in = ST_SPLIT;
               end
            end
         end
         ST_SPLIT: begin
            if (!s_ff[0]) begin
               s_in = s_ff >> 1;
               t_in = t_ff + TW'(1);
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (idx_ff == rounds_ff) begin
               verdict_in = VERDICT_PROBABLE;
               state_in   = ST_RESP;
            end else if (EW'(prime_sel) == p_ext) begin
               verdict_in = VERDICT_PRIME;
               state_in   = ST_RESP;
            end else begin
               base_in  = EW'(prime_sel);
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (base_ff >= p_ext) begin
               base_in = base_ff - p_ext;
            end else begin
               b_in     = base_ff[WIDTH-1:0];
               r_in     = WIDTH'(1);
               e_in     = s_ff;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            if (e_ff == '0) begin
               j_in = '0;
               if (r_ff == WIDTH'(1)) begin
                  idx_in   = idx_ff + ROUNDS_W'(1);
                  state_in = ST_ROUND;
               end else begin
                  state_in = ST_SQ;
               end
            end else begin
               ma_in    = e_ff[0] ? r_ff : b_ff;
               mb_in    = b_ff;
               kind_in  = e_ff[0] ? MUL_R : MUL_B;
               acc_in   = '0;
               cnt_in   = TW'(WIDTH - 1);
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_SQ: begin
            if (j_ff == t_ff) begin
               verdict_in = VERDICT_COMPOSITE;
               state_in   = ST_RESP;
            end else if (r_ff == p_ff - WIDTH'(1)) begin
               idx_in   = idx_ff + ROUNDS_W'(1);
               state_in = ST_ROUND;
            end else begin
               ma_in    = r_ff;
               mb_in    = r_ff;
               kind_in  = MUL_X;
               acc_in   = '0;
               cnt_in   = TW'(WIDTH - 1);
               phase_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!phase_ff) begin
               acc_in   = add_out;
               phase_in = 1'b1;
            end else begin
               if (mb_ff[WIDTH-1]) begin
                  acc_in = add_out;
               end
               mb_in    = mb_ff << 1;
               phase_in = 1'b0;
               cnt_in   = cnt_ff - TW'(1);
               if (cnt_ff == '0) begin
                  unique case (kind_ff)
                     MUL_R: begin
                        r_in     = mb_ff[WIDTH-1] ? add_out : acc_ff;
                        ma_in    = b_ff;
                        mb_in    = b_ff;
                        kind_in  = MUL_B;
                        acc_in   = '0;
                        cnt_in   = TW'(WIDTH - 1);
                        state_in = ST_MUL;
                     end
                     MUL_B: begin
                        b_in     = mb_ff[WIDTH-1] ? add_out : acc_ff;
                        e_in     = e_ff >> 1;
                        state_in = ST_POW;
                     end
                     MUL_X: begin
                        r_in     = mb_ff[WIDTH-1] ? add_out : acc_ff;
                        j_in     = j_ff + TW'(1);
                        state_in = ST_SQ;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_rounds_ff <= ROUNDS_RESET;
      end else begin
         state_ff      <= state_in;
         num_rounds_ff <= num_rounds_in;
      end
   end

   always_ff @(posedge clock) begin
      rounds_ff  <= rounds_in;
      idx_ff     <= idx_in;
      p_ff       <= p_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      t_ff       <= t_in;
      j_ff       <= j_in;
      base_ff    <= base_in;
      r_ff       <= r_in;
      b_ff       <= b_in;
      ma_ff      <= ma_in;
      mb_ff      <= mb_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      phase_ff   <= phase_in;
      kind_ff    <= kind_in;
      verdict_ff <= verdict_in;
   end

endmodule

/* sv/mrpt_checker.sv */
// Port-level checker for the Miller-Rabin unit, bound into every instance of the unit.
module mrpt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [mrpt_pkg::VERDICT_W-1:0] rsp_verdict
);
   import mrpt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("response dropped before transaction");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while verdict pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after request transaction");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("not idle after response transaction");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERDICT_COMPOSITE || rsp_verdict == VERDICT_PROBABLE
                     || rsp_verdict == VERDICT_PRIME))
      else $error("bad verdict code");

endmodule

bind miller_rabin_prime_test_unit mrpt_checker u_mrpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_verdict(rsp_chan.verdict)
);

/* verif/mrpt_checker.sv */
// Checker: watches both channels, predicts each verdict and compares it with the one returned.
module mrpt_scoreboard (
   input  logic                          clock,
   input  logic                          reset,
   mrpt_req_if                           req,
   mrpt_rsp_if                           rsp,
   input  logic                          csr_we,
   input  logic [mrpt_pkg::ROUNDS_W-1:0] csr_wdata,
   output int                            verdicts_owed,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mrpt_pkg::*;

   logic [ROUNDS_W-1:0]  rounds_reg;
   logic [VERDICT_W-1:0] verdicts_due[$];
   int unsigned          witness[BASE_DEPTH_DEF];

   function automatic bit odd_prime_or_two(int unsigned v);
      if (v < 2) return 0;
      for (int unsigned d = 2; d * d <= v; d++) if (v % d == 0) return 0;
      return 1;
   endfunction

   initial begin
      int unsigned v;
      v = 2;
      for (int i = 0; i < BASE_DEPTH_DEF; i++) begin
         while (!odd_prime_or_two(v)) v++;
         witness[i] = v;
         v++;
      end
   end

   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      r = 1;
      b = b % m;
      while (e != 0) begin
         if (e[0]) r = mulmod(r, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [VERDICT_W-1:0] primality_verdict(logic [63:0] p,
                                                             logic [ROUNDS_W-1:0] nr);
      logic [63:0] s, x;
      int          t, lim;
      bit          passed;
      if (p < 2) return VERDICT_COMPOSITE;
      s = p - 1;
      t = 0;
      while (!s[0]) begin
         s = s >> 1;
         t++;
      end
      lim = (nr > BASE_DEPTH_DEF) ? BASE_DEPTH_DEF : nr;
      for (int i = 0; i < lim; i++) begin
         if (64'(witness[i]) == p) return VERDICT_PRIME;
         x = powmod(64'(witness[i]), s, p);
         if (x != 1) begin
            passed = 0;
            for (int j = 0; j < t; j++) begin
               if (x == p - 1) begin
                  passed = 1;
                  break;
               end
               x = mulmod(x, x, p);
            end
            if (!passed) return VERDICT_COMPOSITE;
         end
      end
      return VERDICT_PROBABLE;
   endfunction

   assign verdicts_owed = verdicts_due.size();

   always @(posedge clock) begin
      if (reset) begin
         rounds_reg <= ROUNDS_RESET;
         fail_count <= 0;
      end else begin
         if (csr_we) rounds_reg <= csr_wdata;
         if (req.valid && req.ready)
            verdicts_due.push_back(primality_verdict(req.candidate, rounds_reg));
         if (rsp.valid && rsp.ready) begin
            if (verdicts_due.size() == 0) begin
               if (fail_count < 10) $display("unexpected verdict %0d", rsp.verdict);
               fail_count <= fail_count + 1;
            end else begin
               logic [VERDICT_W-1:0] want;
               want = verdicts_due.pop_front();
               if (want !== rsp.verdict) begin
                  if (fail_count < 10)
                     $display("verdict: expected %0d, got %0d", want, rsp.verdict);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* verif/testbench.sv */
// Top of the testbench: clock, reset, stimulus, watchdog and verdict for the Miller-Rabin unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mrpt_pkg::*;

   localparam int IDLE_LIMIT = 3000000;

   logic                clock = 0;
   logic                reset = 1;
   logic                csr_we = 0;
   logic [ROUNDS_W-1:0] csr_wdata = '0;
   int                  verdicts_owed, fail_count;
   int                  send_idle_pct = 0, recv_idle_pct = 0;
   int                  quiet_cycles = 0;

   mrpt_req_if req ();
   mrpt_rsp_if rsp ();

   miller_rabin_prime_test_unit dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   mrpt_scoreboard chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .verdicts_owed(verdicts_owed), .fail_count(fail_count)
   );

   always #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.candidate = '0;
      rsp.ready = 0;
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("miller_rabin_prime_test_unit: mismatch");
         $finish;
      end
   end

   // valid stays high across back-to-back transactions unless a random gap is inserted
   task automatic send_candidate(logic [63:0] cand);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0 && req.valid) req.valid <= 0;
      if (gap > 0) repeat (gap) @(posedge clock);
      req.valid <= 1;
      req.candidate <= cand;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain_and_set(logic [ROUNDS_W-1:0] nr);
      req.valid <= 0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= nr;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_candidate();
      logic [63:0] v;
      int unsigned k;
      k = $urandom_range(99);
      if (k < 12) return {$urandom(), $urandom()};
      v = 64'($urandom_range(4095));
      if (k < 30) begin
         v = v | 64'd1;
         while (!chk.odd_prime_or_two(int'(v))) v += 2;
      end
      return v;
   endfunction

   initial begin
      logic [63:0] corner[10];
      corner = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd13, 64'd561,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE};
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset setting of 20 rounds
      foreach (corner[i]) send_candidate(corner[i]);
      drain_and_set(7'd0);
      send_candidate(64'd1);
      send_candidate(64'd2);
      send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
      drain_and_set(7'd1);
      send_candidate(64'hFFFF_FFFF_FFFF_FFC5);
      send_candidate(64'd2);
      send_candidate(64'd4);
      send_candidate(64'd3215031751);
      send_candidate(64'h8000_0000_0000_0000);
      drain_and_set(7'd127);
      send_candidate(64'd13);
      send_candidate(64'd313);
      drain_and_set(7'd64);
      send_candidate(64'd311);
      send_candidate(64'd15);

      for (int ph = 0; ph < 3; ph++) begin
         drain_and_set(7'($urandom_range(2, 6)));
         send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 52 : 0;
         recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 14 : 0;
         for (int n = 0; n < 28; n++) send_candidate(random_candidate());
      end
      req.valid <= 0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("miller_rabin_prime_test_unit: match");
      else $display("miller_rabin_prime_test_unit: mismatch");
      $finish;
   end
endmodule
